// File: rtl/s64alu_pkg.sv
// shared types, codes and parameters for the signed 64-bit arithmetic unit
`timescale 1ns / 1ps
package s64alu_pkg;

	localparam int DataW = 64;
	localparam int HalfW = 32;
	// divide stages: 64 quotient bits, this many per stage
	localparam int DivBitsPerStage = 4;
	localparam int DivStages = DataW / DivBitsPerStage;

	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_SUB   = 3'd1;
	localparam logic [2:0] ACT_NEG   = 3'd2;
	localparam logic [2:0] ACT_MUL32 = 3'd3;
	localparam logic [2:0] ACT_MUL64 = 3'd4;
	localparam logic [2:0] ACT_DIV   = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIVZERO  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [63:0] operand_a;
		logic signed [63:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [63:0] result;
		logic [31:0]        remainder;
		logic [1:0]         status;
	} rsp_t;

	// divide working state carried down the divider pipeline
	typedef struct packed {
		logic [63:0] rem_hi;  // partial remainder (fits 33 bits but kept simple below)
		logic [63:0] quo;     // dividend shifting into quotient
		logic [31:0] dvs;     // divisor magnitude
		logic        neg;
		logic        dz;
	} div_t;

endpackage

// File: rtl/s64alu_mul.sv
// pipelined signed multiplier: 32x32 partial products summed over stages
`timescale 1ns / 1ps
module s64alu_mul
	import s64alu_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        m32,
	output logic [63:0] p
);
	// operands brought to 64-bit pattern; product mod 2^64 is the answer
	// for both modes since sign-extended mul32 fits in 64 bits
	logic [63:0] ea, eb;
	assign ea = m32 ? {{HalfW{a[31]}}, a[31:0]} : a;
	assign eb = m32 ? {{HalfW{b[31]}}, b[31:0]} : b;

	// stage 1: register operands
	logic [63:0] a_s1, b_s1;
	always_ff @(posedge clk) begin
		a_s1 <= ea;
		b_s1 <= eb;
	end

	// stage 2: three 32x32 products of the low-64 cross terms (lo*lo, lo*hi, hi*lo)
	logic [63:0] ll_s2, lh_s2, hl_s2;
	always_ff @(posedge clk) begin
		ll_s2 <= 64'(a_s1[31:0]) * 64'(b_s1[31:0]);
		lh_s2 <= 64'(a_s1[31:0] * b_s1[63:32]);
		hl_s2 <= 64'(a_s1[63:32] * b_s1[31:0]);
	end

	// stage 3: combine
	logic [31:0] cross_sum;
	assign cross_sum = lh_s2[31:0] + hl_s2[31:0];
	always_ff @(posedge clk) begin
		p <= ll_s2 + {cross_sum, 32'd0};
	end
endmodule

// File: rtl/s64alu_div.sv
// pipelined restoring divider, 64-bit magnitude by 32-bit magnitude
`timescale 1ns / 1ps
module s64alu_div
	import s64alu_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] quo,
	output logic [31:0] rem,
	output logic        neg,
	output logic        dz
);
	div_t st_q [DivStages+1];
	logic [63:0] sb;

	assign sb = {{HalfW{b[31]}}, b[31:0]};

	always_ff @(posedge clk) begin
		st_q[0].rem_hi <= '0;
		st_q[0].quo    <= a[63] ? 64'(0 - a) : a;
		st_q[0].dvs    <= b[31] ? 32'(0 - b[31:0]) : b[31:0];
		st_q[0].neg    <= a[63] ^ sb[63];
		st_q[0].dz     <= (b[31:0] == '0);
	end

	for (genvar g = 0; g < DivStages; g++) begin : g_stage
		div_t nx;
		always_comb begin
			logic [32:0] r;
			logic [32:0] d;
			nx = st_q[g];
			for (int k = 0; k < DivBitsPerStage; k++) begin
				r = {nx.rem_hi[31:0], nx.quo[63]};
				d = r - {1'b0, nx.dvs};
				nx.quo = {nx.quo[62:0], ~d[32]};
				nx.rem_hi = {32'd0, (d[32] ? r[31:0] : d[31:0])};
			end
		end
		always_ff @(posedge clk) begin
			st_q[g+1] <= nx;
		end
	end

	assign quo = st_q[DivStages].quo;
	assign rem = st_q[DivStages].rem_hi[31:0];
	assign neg = st_q[DivStages].neg;
	assign dz  = st_q[DivStages].dz;
endmodule

// File: rtl/signed_64bit_arithmetic_unit.sv
// top level of the signed 64-bit arithmetic unit
`timescale 1ns / 1ps
// Fully pipelined: a request is taken every cycle (busy is always low), and done
// follows each request through the same delay lines for every action, so
// results leave in request order. The divider, which resolves four quotient
// bits per stage, is the deepest path; the multiplier and adder results are
// delayed to match. The receiver cannot stall, so no buffering is needed.
module signed_64bit_arithmetic_unit
	import s64alu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);
	localparam int Lat = DivStages + 1;  // depth of the divider pipeline including its entry register

	assign busy = 1'b0;

	logic [63:0] mp, dq;
	logic [31:0] dr;
	logic dn, dzf;

	s64alu_mul u_mul (.clk(clk), .a(req.operand_a), .b(req.operand_b),
		.m32(req.action == ACT_MUL32), .p(mp));
	s64alu_div u_div (.clk(clk), .a(req.operand_a), .b(req.operand_b),
		.quo(dq), .rem(dr), .neg(dn), .dz(dzf));

	// add/sub/neg result computed at entry
	logic [63:0] simple;
	always_comb begin
		case (req.action)
			ACT_ADD: simple = req.operand_a + req.operand_b;
			ACT_SUB: simple = req.operand_a - req.operand_b;
			ACT_NEG: simple = 64'd0 - req.operand_a;
			default: simple = '0;
		endcase
	end

	// valid and action/simple result delay lines
	logic        vld_q [Lat+1];
	logic [2:0]  act_q [Lat+1];
	logic [63:0] sim_q [Lat+1];
	logic [63:0] mp_q  [Lat-3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= Lat; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= start;
			for (int i = 1; i <= Lat; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		act_q[0] <= req.action;
		sim_q[0] <= simple;
		for (int i = 1; i <= Lat; i++) begin
			act_q[i] <= act_q[i-1];
			sim_q[i] <= sim_q[i-1];
		end
		// multiplier output is delayed here to line up with the Lat-1 tap
		mp_q[0] <= mp;
		for (int i = 1; i < Lat - 3; i++) mp_q[i] <= mp_q[i-1];
	end

	// final stage: select and sign the quotient
	logic [63:0] sq;
	logic        ovf;
	rsp_t        nx;
	assign sq  = dn ? 64'(0 - dq) : dq;
	assign ovf = dn ? (dq > 64'h8000_0000) : (dq > 64'h7fff_ffff);

	always_comb begin
		nx = '0;
		case (act_q[Lat-1])
			ACT_ADD, ACT_SUB, ACT_NEG: nx.result = sim_q[Lat-1];
			ACT_MUL32, ACT_MUL64: nx.result = mp_q[Lat-4];
			ACT_DIV: begin
				if (dzf) begin
					nx.status = ST_DIVZERO;
				end else begin
					nx.result    = {{HalfW{sq[31]}}, sq[31:0]};
					nx.remainder = dr;
					nx.status    = ovf ? ST_OVERFLOW : ST_OK;
				end
			end
			default: nx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[Lat-1];
		end
	end

	always_ff @(posedge clk) begin
		rsp <= nx;
	end

	// every result strobe answers an earlier request
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, Lat + 1)) else $error("unexpected done");
	// non-divide results never report a divide status
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		done && act_q[Lat] != ACT_DIV |-> rsp.status == ST_OK && rsp.remainder == '0)
		else $error("bad status");
	// never busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
endmodule

// File: sim/alu_checker.sv
// result checker for the signed 64-bit arithmetic unit
`timescale 1ns / 1ps
module alu_checker
	import s64alu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	rsp_t awaited_rsp[$];

	function automatic logic [63:0] sign_ext32(logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [63:0] magnitude(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	function automatic rsp_t compute_rsp(req_t r);
		rsp_t o;
		logic [63:0] sa, sb, p, ma, mb, q, sq;
		logic neg;
		o = '0;
		o.status = ST_OK;
		case (r.action)
			ACT_ADD: o.result = r.operand_a + r.operand_b;
			ACT_SUB: o.result = r.operand_a - r.operand_b;
			ACT_NEG: o.result = -r.operand_a;
			ACT_MUL32: begin
				sa = sign_ext32(r.operand_a);
				sb = sign_ext32(r.operand_b);
				neg = sa[63] ^ sb[63];
				p = magnitude(sa) * magnitude(sb);
				o.result = neg ? -p : p;
			end
			ACT_MUL64: o.result = r.operand_a * r.operand_b;
			ACT_DIV: begin
				sb = sign_ext32(r.operand_b);
				if (r.operand_b[31:0] == 32'd0) begin
					o.status = ST_DIVZERO;
				end else begin
					neg = r.operand_a[63] ^ sb[63];
					ma = magnitude(r.operand_a);
					mb = magnitude(sb);
					q = ma / mb;
					sq = neg ? -q : q;
					o.remainder = 32'(ma % mb);
					if (neg ? (q > 64'h8000_0000) : (q > 64'h7fff_ffff))
						o.status = ST_OVERFLOW;
					o.result = sign_ext32(sq);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	assign pending = awaited_rsp.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, rsp);
					fail_count <= fail_count + 1;
				end else begin
					exp_rsp = awaited_rsp.pop_front();
					if (rsp !== exp_rsp) begin
						$display("%0t: mismatch expected res=%h rem=%h st=%0d actual res=%h rem=%h st=%0d",
							$realtime, exp_rsp.result, exp_rsp.remainder, exp_rsp.status,
							rsp.result, rsp.remainder, rsp.status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				awaited_rsp.push_back(compute_rsp(req));
		end
	end

endmodule

// File: sim/tb_top.sv
// stimulus and verdict for the signed 64-bit arithmetic unit testbench
`timescale 1ns / 1ps
module tb_top;
	import s64alu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t req = '0;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	signed_64bit_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	alu_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	// operand with heavy weight on edge values
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, $urandom};
			3: return 64'(signed'($urandom_range(0, 20)) - 10);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// divisor low word, sometimes zero or extreme
	function automatic logic [63:0] pick_divisor();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v[31:0] = 32'd0;
			1: v[31:0] = 32'h8000_0000;
			2: v[31:0] = 32'hffff_ffff;
			3: v[31:0] = $urandom_range(1, 16);
			default: ;
		endcase
		return v;
	endfunction

	// hold one request until it is taken; idle first with the given odds
	task automatic send_request(logic [2:0] act, logic [63:0] a, logic [63:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{action: act, operand_a: a, operand_b: b};
		do @(posedge clk); while (busy);
	endtask

	initial begin
		logic [2:0] act;
		idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every action with edge operands, plus the divide corner cases
		for (int k = 0; k < 8; k++)
			send_request(3'(k), 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
		send_request(ACT_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1);
		send_request(ACT_SUB, 64'h8000_0000_0000_0000, 64'd1);
		send_request(ACT_NEG, 64'h0, 64'h0);
		send_request(ACT_MUL32, 64'h0000_0000_8000_0000, 64'h0000_0000_8000_0000);
		send_request(ACT_MUL32, 64'hffff_ffff_7fff_ffff, 64'h1234_5678_8000_0000);
		send_request(ACT_MUL64, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
		// divide by zero with nonzero upper word
		send_request(ACT_DIV, 64'd100, 64'hffff_ffff_0000_0000);
		// quotient overflow, two positive cases
		send_request(ACT_DIV, 64'h0000_0001_0000_0000, 64'd1);
		send_request(ACT_DIV, 64'h8000_0000_0000_0000, 64'h0000_0000_ffff_ffff);
		// quotient exactly -2^31 is fine, +2^31 overflows
		send_request(ACT_DIV, 64'hffff_ffff_8000_0000, 64'd1);
		send_request(ACT_DIV, 64'h0000_0000_8000_0000, 64'd1);
		send_request(ACT_DIV, 64'hffff_ffff_ffff_fff9, 64'd2);
		send_request(ACT_DIV, 64'd7, 64'h0000_0000_8000_0000);
		send_request(ACT_DIV, 64'h8000_0000_0000_0000, 64'h0000_0000_8000_0000);

		// random phases: sender idles 17%, then 68%, then never
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 17 : (ph == 1) ? 68 : 0;
			repeat (345) begin
				act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
					: 3'($urandom_range(0, 5));
				send_request(act, pick_operand(),
					(act == ACT_DIV) ? pick_divisor() : pick_operand());
			end
		end
		start <= 1'b0;

		// drain, then a margin for the pipeline depth
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/s64alu_pkg.sv
rtl/s64alu_mul.sv
rtl/s64alu_div.sv
rtl/signed_64bit_arithmetic_unit.sv
sim/alu_checker.sv
sim/tb_top.sv
